// ----- rtl/matrix3_inverse_assert.svh -----
// ----------------------------------------------------------------------------
// matrix3_inverse_assert.svh
// Assertion macros for the matrix3_inverse checker. The enclosing
// scope must provide clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH

// same-cycle implication
`define M3INV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define M3INV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/m3inv_pkg.sv -----
// ----------------------------------------------------------------------------
// m3inv_pkg
// Widths, payload types and constant tables of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int unsigned IO_BITS       = 32;
  localparam int unsigned ENTRY_BITS    = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned LANES         = 9;

  localparam int unsigned PROD_W  = 2 * ENTRY_BITS;
  localparam int unsigned COF_W   = PROD_W + 1;
  localparam int unsigned MAG_W   = COF_W;
  localparam int unsigned PART_W  = 2 * ENTRY_BITS + 1;
  localparam int unsigned PSUM_W  = PART_W + 2;
  localparam int unsigned DET_W   = 3 * ENTRY_BITS + 3;
  localparam int unsigned SHIFT   = 2 * FRACTION_BITS;
  localparam int unsigned NUM_W   = MAG_W + SHIFT;
  localparam int unsigned HI_W    = NUM_W - ENTRY_BITS;
  localparam int unsigned REM_W   = ((HI_W > DET_W) ? HI_W : DET_W) + 1;

  localparam int unsigned FRONT_STAGES = 6;
  localparam int unsigned DIV_STAGES   = ENTRY_BITS + 1;

  typedef logic signed [IO_BITS-1:0]    io_t;
  typedef logic signed [ENTRY_BITS-1:0] ent_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [COF_W-1:0]      cof_t;
  typedef logic signed [PART_W-1:0]     part_t;
  typedef logic signed [PSUM_W-1:0]     psum_t;
  typedef logic signed [DET_W-1:0]      det_t;
  typedef logic [DET_W-1:0]             dmag_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [ENTRY_BITS-1:0]        quo_t;

  localparam quo_t QUO_HALF = {1'b1, {(ENTRY_BITS-1){1'b0}}};
  localparam io_t  SAT_MAX  = io_t'((64'sd1 <<< (ENTRY_BITS-1)) - 64'sd1);
  localparam io_t  SAT_MIN  = io_t'(-(64'sd1 <<< (ENTRY_BITS-1)));

  // cofactor l = a[p]*a[q] - a[s]*a[t], entries in row-major order
  localparam int unsigned COF_SEL [LANES][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    io_t entry_r0c0;
    io_t entry_r0c1;
    io_t entry_r0c2;
    io_t entry_r1c0;
    io_t entry_r1c1;
    io_t entry_r1c2;
    io_t entry_r2c0;
    io_t entry_r2c1;
    io_t entry_r2c2;
  } req_t;

  typedef struct packed {
    io_t  inv_r0c0;
    io_t  inv_r0c1;
    io_t  inv_r0c2;
    io_t  inv_r1c0;
    io_t  inv_r1c1;
    io_t  inv_r1c2;
    io_t  inv_r2c0;
    io_t  inv_r2c1;
    io_t  inv_r2c2;
    logic singular;
    logic overflow;
  } rsp_t;

  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             sing;
  } tag_t;

endpackage

// ----- rtl/m3inv_if.sv -----
// ----------------------------------------------------------------------------
// m3inv_if
// Valid/ready channels carrying a matrix request and its inverse.
// ----------------------------------------------------------------------------
interface m3inv_req_if;
  import m3inv_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface m3inv_rsp_if;
  import m3inv_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/m3inv_div.sv -----
// ----------------------------------------------------------------------------
// m3inv_div
// Nine-lane pipelined restoring divider: (mag << SHIFT) / dmag, one quotient
// bit per stage, with a flag for quotients at or above 2^ENTRY_BITS.
// ----------------------------------------------------------------------------
module m3inv_div (
  input  logic                clk_i,
  input  logic                en_i,
  input  m3inv_pkg::mag_t     mag_i [m3inv_pkg::LANES],
  input  m3inv_pkg::dmag_t    dmag_i,
  input  m3inv_pkg::tag_t     tag_i,
  output m3inv_pkg::quo_t     quo_o [m3inv_pkg::LANES],
  output logic                big_o [m3inv_pkg::LANES],
  output m3inv_pkg::tag_t     tag_o
);
  import m3inv_pkg::*;

  logic [REM_W-1:0] rem_q [DIV_STAGES][LANES];
  quo_t             quo_q [DIV_STAGES][LANES];
  quo_t             low_q [DIV_STAGES][LANES];
  logic             big_q [DIV_STAGES][LANES];
  dmag_t            d_q   [DIV_STAGES];
  tag_t             tag_q [DIV_STAGES];

  logic [NUM_W-1:0] num [LANES];
  logic [HI_W-1:0]  hi  [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num[l] = {mag_i[l], {SHIFT{1'b0}}};
      hi[l]  = num[l][NUM_W-1:ENTRY_BITS];
    end
  end

  // stage 0: high part of the numerator; at or above the divisor means overflow
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0]   <= dmag_i;
      tag_q[0] <= tag_i;
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= REM_W'(hi[l]);
        low_q[0][l] <= num[l][ENTRY_BITS-1:0];
        quo_q[0][l] <= '0;
        big_q[0][l] <= REM_W'(hi[l]) >= REM_W'(dmag_i);
      end
    end
  end

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_step
    logic [REM_W-1:0] trial [LANES];
    logic             ge    [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_q[s-1][l][REM_W-2:0], low_q[s-1][l][ENTRY_BITS-1]};
        ge[l]    = trial[l] >= REM_W'(d_q[s-1]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s]   <= d_q[s-1];
        tag_q[s] <= tag_q[s-1];
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= ge[l] ? trial[l] - REM_W'(d_q[s-1]) : trial[l];
          quo_q[s][l] <= {quo_q[s-1][l][ENTRY_BITS-2:0], ge[l]};
          low_q[s][l] <= {low_q[s-1][l][ENTRY_BITS-2:0], 1'b0};
          big_q[s][l] <= big_q[s-1][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = quo_q[DIV_STAGES-1][l];
      big_o[l] = big_q[DIV_STAGES-1][l];
    end
  end

  assign tag_o = tag_q[DIV_STAGES-1];

endmodule

// ----- rtl/matrix3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 matrix inverse by adjugate over determinant, Q16.16 in and out.
//
// req_i carries one matrix per request, rsp_o its inverse with the
// singular and overflow flags; both are valid/ready channels.
// A request passes the front end (32x32 products, cofactor subtraction,
// determinant products, sums and magnitude), the nine-lane bit-per-stage
// divider, which makes up most of the depth, and one output register.
// A new request is taken every cycle unless the receiver stalls.
// When the receiver stalls with a response waiting, the whole pipeline
// holds and req_i.ready drops in the same cycle; nothing is lost or
// repeated. Reset empties the pipeline and drops rsp_o.valid.
// A zero determinant gives an all-zero inverse with singular set.
// ----------------------------------------------------------------------------
module matrix3_inverse (
  input  logic          clk_i,
  input  logic          rst_ni,
  m3inv_req_if.sink     req_i,
  m3inv_rsp_if.source   rsp_o
);
  import m3inv_pkg::*;

  localparam int unsigned NST = FRONT_STAGES + DIV_STAGES;

  logic           en;
  logic [NST-1:0] vld_q;
  logic           rsp_vld_q;
  rsp_t           rsp_q, rsp_d;

  ent_t  ent [LANES];
  prod_t pa_q [LANES], pb_q [LANES];
  ent_t  e1_q [3], e2_q [3];
  cof_t  c2_q [LANES], c3_q [LANES], c4_q [LANES], c5_q [LANES];
  part_t plo_q [3], phi_q [3];
  psum_t slo_q, shi_q;
  det_t  det_q;
  mag_t  mag_q [LANES];
  dmag_t dmag_q;
  tag_t  tag_q, tag_div;
  quo_t  quo_div [LANES];
  logic  big_div [LANES];

  assign en          = !rsp_vld_q || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    ent[0] = req_i.data.entry_r0c0[ENTRY_BITS-1:0];
    ent[1] = req_i.data.entry_r0c1[ENTRY_BITS-1:0];
    ent[2] = req_i.data.entry_r0c2[ENTRY_BITS-1:0];
    ent[3] = req_i.data.entry_r1c0[ENTRY_BITS-1:0];
    ent[4] = req_i.data.entry_r1c1[ENTRY_BITS-1:0];
    ent[5] = req_i.data.entry_r1c2[ENTRY_BITS-1:0];
    ent[6] = req_i.data.entry_r2c0[ENTRY_BITS-1:0];
    ent[7] = req_i.data.entry_r2c1[ENTRY_BITS-1:0];
    ent[8] = req_i.data.entry_r2c2[ENTRY_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NST-2:0], req_i.valid};
      rsp_vld_q <= vld_q[NST-1];
    end
  end

  // front end: products, cofactors, determinant, magnitudes
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        pa_q[l] <= ent[COF_SEL[l][0]] * ent[COF_SEL[l][1]];
        pb_q[l] <= ent[COF_SEL[l][2]] * ent[COF_SEL[l][3]];
        c2_q[l] <= COF_W'(pa_q[l]) - COF_W'(pb_q[l]);
        c3_q[l] <= c2_q[l];
        c4_q[l] <= c3_q[l];
        c5_q[l] <= c4_q[l];
        mag_q[l]     <= c5_q[l][COF_W-1] ? MAG_W'(-c5_q[l]) : MAG_W'(c5_q[l]);
        tag_q.neg[l] <= c5_q[l][COF_W-1] ^ det_q[DET_W-1];
      end
      for (int k = 0; k < 3; k++) begin
        e1_q[k]  <= ent[k];
        e2_q[k]  <= e1_q[k];
        plo_q[k] <= $signed({1'b0, c2_q[3*k][ENTRY_BITS-1:0]}) * e2_q[k];
        phi_q[k] <= $signed(c2_q[3*k][COF_W-1:ENTRY_BITS]) * e2_q[k];
      end
      slo_q      <= PSUM_W'(plo_q[0]) + PSUM_W'(plo_q[1]) + PSUM_W'(plo_q[2]);
      shi_q      <= PSUM_W'(phi_q[0]) + PSUM_W'(phi_q[1]) + PSUM_W'(phi_q[2]);
      det_q      <= (DET_W'(shi_q) <<< ENTRY_BITS) + DET_W'(slo_q);
      dmag_q     <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
      tag_q.sing <= det_q == '0;
    end
  end

  m3inv_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (mag_q),
    .dmag_i (dmag_q),
    .tag_i  (tag_q),
    .quo_o  (quo_div),
    .big_o  (big_div),
    .tag_o  (tag_div)
  );

  // sign, saturation and singular handling
  io_t res [LANES];
  logic ovf;

  always_comb begin
    quo_t q;
    logic sat;
    ovf = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      q = quo_div[l];
      if (tag_div.neg[l]) begin
        sat = big_div[l] || (q > QUO_HALF);
        q   = sat ? QUO_HALF : q;
        q   = -q;
      end else begin
        sat = big_div[l] || q[ENTRY_BITS-1];
        q   = sat ? (QUO_HALF - quo_t'(1)) : q;
      end
      res[l] = tag_div.sing ? '0 : IO_BITS'($signed(q));
      ovf    = ovf | (sat & !tag_div.sing);
    end
    rsp_d.inv_r0c0 = res[0];
    rsp_d.inv_r0c1 = res[1];
    rsp_d.inv_r0c2 = res[2];
    rsp_d.inv_r1c0 = res[3];
    rsp_d.inv_r1c1 = res[4];
    rsp_d.inv_r1c2 = res[5];
    rsp_d.inv_r2c0 = res[6];
    rsp_d.inv_r2c1 = res[7];
    rsp_d.inv_r2c2 = res[8];
    rsp_d.singular = tag_div.sing;
    rsp_d.overflow = ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

// ----- rtl/m3inv_chk.sv -----
// ----------------------------------------------------------------------------
// m3inv_chk
// Port-level checks of matrix3_inverse, attached by bind.
// ----------------------------------------------------------------------------
`include "matrix3_inverse_assert.svh"

module m3inv_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input m3inv_pkg::rsp_t   rsp_data_i
);
  import m3inv_pkg::*;

  logic all_zero;
  logic any_sat;

  assign all_zero = rsp_data_i.inv_r0c0 == '0 && rsp_data_i.inv_r0c1 == '0 &&
                    rsp_data_i.inv_r0c2 == '0 && rsp_data_i.inv_r1c0 == '0 &&
                    rsp_data_i.inv_r1c1 == '0 && rsp_data_i.inv_r1c2 == '0 &&
                    rsp_data_i.inv_r2c0 == '0 && rsp_data_i.inv_r2c1 == '0 &&
                    rsp_data_i.inv_r2c2 == '0;

  assign any_sat =
    rsp_data_i.inv_r0c0 == SAT_MAX || rsp_data_i.inv_r0c0 == SAT_MIN ||
    rsp_data_i.inv_r0c1 == SAT_MAX || rsp_data_i.inv_r0c1 == SAT_MIN ||
    rsp_data_i.inv_r0c2 == SAT_MAX || rsp_data_i.inv_r0c2 == SAT_MIN ||
    rsp_data_i.inv_r1c0 == SAT_MAX || rsp_data_i.inv_r1c0 == SAT_MIN ||
    rsp_data_i.inv_r1c1 == SAT_MAX || rsp_data_i.inv_r1c1 == SAT_MIN ||
    rsp_data_i.inv_r1c2 == SAT_MAX || rsp_data_i.inv_r1c2 == SAT_MIN ||
    rsp_data_i.inv_r2c0 == SAT_MAX || rsp_data_i.inv_r2c0 == SAT_MIN ||
    rsp_data_i.inv_r2c1 == SAT_MAX || rsp_data_i.inv_r2c1 == SAT_MIN ||
    rsp_data_i.inv_r2c2 == SAT_MAX || rsp_data_i.inv_r2c2 == SAT_MIN;

  `M3INV_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_data_i), "response changed while stalled")
  `M3INV_ASSERT_IMP(a_backpressure, !req_ready_i, rsp_valid_i && !rsp_ready_i, "request stalled without output stall")
  `M3INV_ASSERT_IMP(a_singular_zero, rsp_valid_i && rsp_data_i.singular, all_zero && !rsp_data_i.overflow, "singular response not zero")
  `M3INV_ASSERT_IMP(a_overflow_sat, rsp_valid_i && rsp_data_i.overflow, any_sat, "overflow without saturated entry")

endmodule

bind matrix3_inverse m3inv_chk u_m3inv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
